/* src/assert_macros.svh */
// Assertion helpers used by fifo_bucket_priority_queue.
// Each use sits at the end of a module that has clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle that ante holds.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante holds.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/fbpq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fbpq_pkg;

  // Queue geometry
  localparam int NUM_KEYS     = 1024;
  localparam int CAPACITY     = 1024;
  localparam int COST_BITS    = 16;
  localparam int HANDLE_W     = 10;
  localparam int HANDLE_SPACE = 1 << HANDLE_W;
  localparam int KEY_W        = $clog2(NUM_KEYS);
  localparam int KEY_SUM_W    = COST_BITS + 1;
  localparam int COUNT_W      = 11;

  // Non-empty bitmap: rows of BMP_W bits, one summary bit per row
  localparam int BMP_W    = 32;
  localparam int COL_W    = $clog2(BMP_W);
  localparam int BMP_ROWS = NUM_KEYS / BMP_W;
  localparam int ROW_W    = $clog2(BMP_ROWS);

  // Stream word widths
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;

  // Action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_POP    = 1'b1;

  // Key mode codes
  localparam logic [1:0] MODE_COST = 2'd0;
  localparam logic [1:0] MODE_HEUR = 2'd1;
  localparam logic [1:0] MODE_SUM  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_POPPED   = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_REJECTED = 2'd3;

  typedef struct packed {
    logic [1:0]         status;
    logic [HANDLE_W-1:0] handle;
    logic [KEY_W-1:0]    key;
    logic [COUNT_W-1:0]  count;
  } res_t;

endpackage

`default_nettype wire

/* src/fbpq_ffs.sv */
`timescale 1ns / 1ps
`default_nettype none

// Find the lowest set bit of a bitmap word.
module fbpq_ffs (
  input  logic [fbpq_pkg::BMP_W-1:0] vec_i,
  output logic [fbpq_pkg::COL_W-1:0] idx_o,
  output logic                       found_o
);
  import fbpq_pkg::*;

  // Scan from the top so the lowest set bit wins
  always_comb begin
    idx_o = '0;
    for (int i = BMP_W - 1; i >= 0; i--) begin
      if (vec_i[i]) begin
        idx_o = COL_W'(i);
      end
    end
  end

  assign found_o = |vec_i;

endmodule

`default_nettype wire

/* src/fifo_bucket_priority_queue.sv */
// Channel    Dir  Handshake                      Payload (lowest bit first)
// s_axis     in   s_axis_tvalid_i/tready_o       tuser: action; tdata: handle, cost, heuristic
// m_axis     out  m_axis_tvalid_o/tready_i       tuser: status; tdata: handle, key, count
// cfg        in   cfg_valid_i/cfg_ready_o        cfg_data_i: key_mode
//
// An insert uses S_INS; a pop S_POP_ROW, S_POP_COL, S_POP_RD, S_POP_WR; an empty pop only S_POP_ROW.
// The pop path is set by the bitmap row read, the link read after the head read,
// and the shared lowest-bit finder that is used once on the row summary and once on a row.
// After reset a clearing pass zeroes the 32 bitmap rows in turn; no word is taken then.
// A result waits in the output register; the next word is accepted meanwhile, and the
// item after it stalls in its final cycle until the output register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fifo_bucket_priority_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // cfg
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [1:0]                          cfg_data_i,      // key_mode
  // input stream
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic                                s_axis_tuser_i,  // action
  input  logic [fbpq_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,  // handle, cost, heuristic
  // output stream
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [1:0]                          m_axis_tuser_o,  // status
  output logic [fbpq_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o   // handle, key, count
);
  import fbpq_pkg::*;

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_INS     = 3'd2;
  localparam logic [2:0] S_POP_ROW = 3'd3;
  localparam logic [2:0] S_POP_COL = 3'd4;
  localparam logic [2:0] S_POP_RD  = 3'd5;
  localparam logic [2:0] S_POP_WR  = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [1:0]           mode_q;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic [BMP_ROWS-1:0]  summary_q, summary_d;
  logic [KEY_SUM_W-1:0] key_q, key_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [ROW_W-1:0]     clr_q, clr_d;
  logic [HANDLE_W-1:0]  hnd_q, hnd_d;
  res_t                 res_q, res_d;
  logic                 out_valid_q;
  logic                 res_load;

  // Memories
  logic [HANDLE_W-1:0] head_mem [NUM_KEYS];
  logic [HANDLE_W-1:0] tail_mem [NUM_KEYS];
  logic [HANDLE_W-1:0] link_mem [HANDLE_SPACE];
  logic [BMP_W-1:0]    bmp_mem  [BMP_ROWS];
  logic [HANDLE_W-1:0] head_rdata, tail_rdata, link_rdata;
  logic [BMP_W-1:0]    bmp_rdata;
  logic                head_we, tail_we, link_we, bmp_we;
  logic [HANDLE_W-1:0] head_wdata;
  logic [BMP_W-1:0]    bmp_wdata;
  logic [ROW_W-1:0]    bmp_waddr;

  logic [HANDLE_W-1:0]  in_handle;
  logic [COST_BITS-1:0] in_cost, in_heur;
  logic [KEY_SUM_W-1:0] key_sum;
  logic                 s_fire, out_free;
  logic [BMP_W-1:0]     enc_vec, col_bit, row_set, row_clr;
  logic [COL_W-1:0]     enc_idx;
  logic                 enc_found;

  // Unpack input word
  assign in_handle = s_axis_tdata_i[HANDLE_W-1:0];
  assign in_cost   = s_axis_tdata_i[HANDLE_W +: COST_BITS];
  assign in_heur   = s_axis_tdata_i[HANDLE_W+COST_BITS +: COST_BITS];

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // Select the bucket key
  always_comb begin
    case (mode_q)
      MODE_COST: key_sum = KEY_SUM_W'(in_cost);
      MODE_HEUR: key_sum = KEY_SUM_W'(in_heur);
      default:   key_sum = KEY_SUM_W'(in_cost) + KEY_SUM_W'(in_heur);
    endcase
  end

  // Shared lowest-bit finder: row summary first, then the chosen row
  assign enc_vec = (state_q == S_POP_ROW) ? summary_q : bmp_rdata;

  fbpq_ffs u_ffs (
    .vec_i   (enc_vec),
    .idx_o   (enc_idx),
    .found_o (enc_found)
  );

  assign col_bit = BMP_W'(1) << key_q[COL_W-1:0];
  assign row_set = bmp_rdata | col_bit;
  assign row_clr = bmp_rdata & ~col_bit;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    summary_d  = summary_q;
    key_d      = key_q;
    row_d      = row_q;
    clr_d      = clr_q;
    hnd_d      = hnd_q;
    res_d      = res_q;
    res_load   = 1'b0;
    head_we    = 1'b0;
    tail_we    = 1'b0;
    link_we    = 1'b0;
    bmp_we     = 1'b0;
    head_wdata = hnd_q;
    bmp_wdata  = row_set;
    bmp_waddr  = row_q;
    case (state_q)
      S_CLEAR: begin
        bmp_we    = 1'b1;
        bmp_wdata = '0;
        bmp_waddr = clr_q;
        if (clr_q == ROW_W'(BMP_ROWS - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + ROW_W'(1);
        end
      end
      S_IDLE: begin
        if (s_fire) begin
          hnd_d   = in_handle;
          key_d   = key_sum;
          row_d   = key_sum[KEY_W-1:COL_W];
          state_d = (s_axis_tuser_i == ACT_POP) ? S_POP_ROW : S_INS;
        end
      end
      S_INS: begin
        if (out_free) begin
          res_load = 1'b1;
          state_d  = S_IDLE;
          if (key_q >= KEY_SUM_W'(NUM_KEYS) || count_q == COUNT_W'(CAPACITY)) begin
            res_d = '{status: ST_REJECTED, handle: '0, key: '0, count: count_q};
          end else begin
            // Append to the bucket tail, or open the bucket
            tail_we = 1'b1;
            if (bmp_rdata[key_q[COL_W-1:0]]) begin
              link_we = 1'b1;
            end else begin
              head_we            = 1'b1;
              bmp_we             = 1'b1;
              summary_d[row_q]   = 1'b1;
            end
            count_d = count_q + COUNT_W'(1);
            res_d   = '{status: ST_INSERTED, handle: '0, key: '0, count: count_d};
          end
        end
      end
      S_POP_ROW: begin
        if (count_q == '0 || !enc_found) begin
          if (out_free) begin
            res_load = 1'b1;
            res_d    = '{status: ST_EMPTY, handle: '0, key: '0, count: count_q};
            state_d  = S_IDLE;
          end
        end else begin
          row_d   = enc_idx;
          state_d = S_POP_COL;
        end
      end
      S_POP_COL: begin
        key_d   = KEY_SUM_W'({row_q, enc_idx});
        state_d = S_POP_RD;
      end
      S_POP_RD: begin
        state_d = S_POP_WR;
      end
      S_POP_WR: begin
        if (out_free) begin
          // Drop the oldest node; close the bucket when it was the last
          if (head_rdata == tail_rdata) begin
            bmp_we    = 1'b1;
            bmp_wdata = row_clr;
            if (row_clr == '0) begin
              summary_d[row_q] = 1'b0;
            end
          end else begin
            head_we    = 1'b1;
            head_wdata = link_rdata;
          end
          count_d  = count_q - COUNT_W'(1);
          res_load = 1'b1;
          res_d    = '{status: ST_POPPED, handle: head_rdata,
                       key: key_q[KEY_W-1:0], count: count_d};
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      mode_q      <= MODE_COST;
      count_q     <= '0;
      summary_q   <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      summary_q <= summary_d;
      clr_q     <= clr_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_data_i;
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    row_q <= row_d;
    hnd_q <= hnd_d;
    if (res_load) begin
      res_q <= res_d;
    end
  end

  // Bucket head memory
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[key_q[KEY_W-1:0]] <= head_wdata;
    end
    head_rdata <= head_mem[key_d[KEY_W-1:0]];
  end

  // Bucket tail memory
  always_ff @(posedge clk_i) begin
    if (tail_we) begin
      tail_mem[key_q[KEY_W-1:0]] <= hnd_q;
    end
    tail_rdata <= tail_mem[key_d[KEY_W-1:0]];
  end

  // Per-node link memory
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[tail_rdata] <= hnd_q;
    end
    link_rdata <= link_mem[head_rdata];
  end

  // Non-empty bitmap rows
  always_ff @(posedge clk_i) begin
    if (bmp_we) begin
      bmp_mem[bmp_waddr] <= bmp_wdata;
    end
    bmp_rdata <= bmp_mem[row_d];
  end

  // Output word
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = res_q.status;
  assign m_axis_tdata_o  = {1'b0, res_q.count, res_q.key, res_q.handle};

  `ASSERT_SAME(a_count_cap, 1'b1, count_q <= COUNT_W'(CAPACITY), "count above capacity")
  `ASSERT_SAME(a_clear_summary, state_q == S_CLEAR, summary_q == '0, "summary set during clear")
  `ASSERT_NEXT(a_pop_dec, res_load && (res_d.status == ST_POPPED), count_q == $past(count_q) - COUNT_W'(1), "pop did not decrement count")
  `ASSERT_NEXT(a_ins_inc, res_load && (res_d.status == ST_INSERTED), count_q == $past(count_q) + COUNT_W'(1), "insert did not increment count")
  `ASSERT_NEXT(a_start, s_fire, state_q != S_IDLE, "accepted word did not start work")

endmodule

`default_nettype wire
